@@ rtl/tkm_pkg.sv @@
// Package for the touch-key Morse decoder.
// Holds the state, configuration, item and result types, the register indexes and reset values.
// No dependencies.
package tkm_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HYSTERESIS_LIMIT = 2'd0,
    REG_DASH_THRESHOLD   = 2'd1,
    REG_GAP_THRESHOLD    = 2'd2
  } reg_index_t;

  // register reset values
  localparam logic [7:0] HYSTERESIS_LIMIT_RESET = 8'd20;
  localparam logic [7:0] DASH_THRESHOLD_RESET   = 8'h30;
  localparam logic [7:0] GAP_THRESHOLD_RESET    = 8'h50;

  // symbol code that toggles shift instead of being committed
  localparam logic [7:0] SHIFT_CODE = 8'd30;
  localparam logic [7:0] COUNT_MAX  = 8'hff;

  typedef struct packed {
    logic [7:0] hysteresis_limit;
    logic [7:0] dash_threshold;
    logic [7:0] gap_threshold;
  } tkm_cfg_t;

  typedef struct packed {
    logic       filtered_level;
    logic       previous_level;
    logic [7:0] disagree_count;
    logic [7:0] gap_timer;
    logic       timeout_seen;
    logic [7:0] code_accum;
    logic [7:0] length_accum;
    logic       shift_state;
  } tkm_state_t;

  typedef struct packed {
    logic touch_raw;
    logic sample_valid;
    logic timer_tick;
  } tkm_item_t;

  typedef struct packed {
    logic       key_level;
    logic       symbol_valid;
    logic [7:0] symbol_code;
    logic [7:0] symbol_length;
    logic       shift_active;
  } tkm_result_t;

endpackage

@@ rtl/tkm_step.sv @@
// Next-state and result logic for one item of the touch-key Morse decoder.
// Purely combinational: hysteresis, gap timer, timeout check, then edge handling.
// Depends on tkm_pkg.
module tkm_step (
  input  tkm_pkg::tkm_cfg_t    cfg,
  input  tkm_pkg::tkm_state_t  state,
  input  tkm_pkg::tkm_item_t   item,
  output tkm_pkg::tkm_state_t  state_next,
  output tkm_pkg::tkm_result_t result
);
  import tkm_pkg::*;

  logic [7:0] count_inc;
  logic [7:0] threshold;
  logic       timeout_hit;
  logic [7:0] element;

  assign count_inc = state.disagree_count + 8'd1;

  always_comb begin
    state_next = state;
    result     = '0;
    threshold  = 8'd0;
    timeout_hit = 1'b0;
    element    = 8'd0;

    // hysteresis on fresh samples
    if (item.sample_valid) begin
      if (item.touch_raw != state.filtered_level) begin
        if (count_inc > cfg.hysteresis_limit) begin
          state_next.disagree_count = 8'd0;
          state_next.filtered_level = item.touch_raw;
        end else begin
          state_next.disagree_count = count_inc;
        end
      end else begin
        state_next.disagree_count = 8'd0;
      end
    end

    // saturating gap timer
    if (item.timer_tick && (state.gap_timer != COUNT_MAX)) begin
      state_next.gap_timer = state.gap_timer + 8'd1;
    end

    // timeout: dash time while down, symbol gap while up
    threshold   = state.previous_level ? cfg.dash_threshold : cfg.gap_threshold;
    timeout_hit = !state.timeout_seen && (state_next.gap_timer > threshold);
    if (timeout_hit) begin
      state_next.timeout_seen = 1'b1;
      if (!state.previous_level) begin
        if (state.code_accum == SHIFT_CODE) begin
          state_next.shift_state = ~state.shift_state;
        end else if (state.length_accum != 8'd0) begin
          result.symbol_valid  = 1'b1;
          result.symbol_code   = state.code_accum;
          result.symbol_length = state.length_accum;
        end
        state_next.code_accum   = 8'd0;
        state_next.length_accum = 8'd0;
      end
    end

    // level change; a release appends a dot or a dash
    if (state_next.filtered_level != state.previous_level) begin
      state_next.previous_level = state_next.filtered_level;
      if (!state_next.filtered_level) begin
        element = state_next.timeout_seen ? 8'd2 : 8'd1;
        state_next.code_accum = {state_next.code_accum[6:0], 1'b0} + element;
        if (state_next.length_accum != COUNT_MAX) begin
          state_next.length_accum = state_next.length_accum + 8'd1;
        end
      end
      state_next.gap_timer    = 8'd0;
      state_next.timeout_seen = 1'b0;
    end

    result.key_level    = state_next.filtered_level;
    result.shift_active = state_next.shift_state;
  end

endmodule

@@ rtl/touch_key_morse_decoder.sv @@
// Touch-key Morse decoder, top level: input register, configuration registers,
// decoder state and result register. Depends on tkm_pkg and tkm_step.
//
// Each transaction on the input stream carries one touch sample and timer tick and
// gives exactly one result transaction. An item is captured in an input register,
// decoded by a single pass of short logic against the decoder state and lands in a
// result register, so the block takes one item per clock while the result side is
// not stalled. While a finished result waits, the input register still takes one more
// transaction; with the result side stalled the block then holds two items and
// drops s_axis_tready until the result register frees. Configuration writes are
// always accepted and take effect on the next item decoded; indexes beyond the
// register list are ignored.
module touch_key_morse_decoder (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [0] touch_raw, [1] timer_tick, rest zero
  input  logic        s_axis_tuser,  // [0] sample_valid
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] key_level, [8:1] symbol_code, [16:9] symbol_length, [17] shift_active
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,  // [0] symbol_valid
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tkm_pkg::*;

  tkm_cfg_t    cfg;
  tkm_state_t  state;
  tkm_state_t  state_next;
  tkm_item_t   item;
  tkm_item_t   item_in;
  tkm_result_t result;
  tkm_result_t result_next;
  logic        item_valid;
  logic        out_free;
  logic        advance;

  // handshake: the result register frees when empty or being taken
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = item_valid && out_free;
  assign s_axis_tready = !item_valid || out_free;
  assign cfg_ready     = 1'b1;

  assign item_in.touch_raw    = s_axis_tdata[0];
  assign item_in.timer_tick   = s_axis_tdata[1];
  assign item_in.sample_valid = s_axis_tuser;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hysteresis_limit <= HYSTERESIS_LIMIT_RESET;
      cfg.dash_threshold   <= DASH_THRESHOLD_RESET;
      cfg.gap_threshold    <= GAP_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HYSTERESIS_LIMIT: cfg.hysteresis_limit <= cfg_data;
        REG_DASH_THRESHOLD:   cfg.dash_threshold   <= cfg_data;
        REG_GAP_THRESHOLD:    cfg.gap_threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item <= item_in;
    end
  end

  // decode logic
  tkm_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result_next)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign m_axis_tdata = {6'd0, result.shift_active, result.symbol_length,
                         result.symbol_code, result.key_level};
  assign m_axis_tuser = result.symbol_valid;

endmodule
